### rtl/m61_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61_pkg: shared types and constants for the p = 2^61-1 field unit
// Holds op codes, the field modulus, and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package m61_pkg;

  localparam int FBits = 61;
  localparam logic [60:0] FieldP = {61{1'b1}};
  // exponent p-2 for inversion
  localparam logic [60:0] InvExp = {{59{1'b1}}, 2'b01};
  localparam int ExpCntW = 6;
  localparam logic [ExpCntW-1:0] ExpLast = ExpCntW'(FBits - 1);

  typedef enum logic [3:0] {
    OP_RED64  = 4'd0,
    OP_RED128 = 4'd1,
    OP_NEG    = 4'd2,
    OP_ADD2   = 4'd3,
    OP_ADD3   = 4'd4,
    OP_ADD4   = 4'd5,
    OP_SUB    = 4'd6,
    OP_MUL    = 4'd7,
    OP_INV    = 4'd8
  } op_t;

  // multiplier source select
  typedef enum logic [1:0] {
    MSEL_AB   = 2'd0,
    MSEL_ACC  = 2'd1,
    MSEL_BASE = 2'd2
  } msel_t;

  typedef struct packed {
    logic  load;      // capture request operands
    logic  simple;    // compute non-multiply result into result register
    logic  mul_go;    // launch a multiply
    msel_t msel;
    logic  wr_acc;    // write reduced product to accumulator
    logic  wr_base;   // write reduced product to base
    logic  wr_res;    // write reduced product to result
    logic  acc_to_res;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_inv;
  } stat_t;

  function automatic logic [60:0] fold64(input logic [63:0] w);
    logic [61:0] s;
    s = {59'd0, w[63:61]} + {1'b0, w[60:0]};
    if (s >= {1'b0, FieldP}) s = s - {1'b0, FieldP};
    return s[60:0];
  endfunction

  function automatic logic [60:0] fadd(input logic [60:0] x, input logic [60:0] y);
    logic [61:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, FieldP}) s = s - {1'b0, FieldP};
    return s[60:0];
  endfunction

endpackage

### rtl/mersenne61_field_alu.sv
`timescale 1ns / 1ps
// Sequencing: a reduce, negate, add or subtract request passes the decode state
// and its result is registered; a multiply passes decode, then the multiply-fold path
// (partial products, sum, fold); invert loops over the same shared multiply-fold path.
// One request in flight: the next is taken in idle, once the result has left,
// so a new request is not accepted while the last one is still in progress.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// mersenne61_field_alu: arithmetic unit over the field mod 2^61-1
// Controller sequences a datapath with add/sub logic and a multiply-fold unit.
// ----------------------------------------------------------------------------
module mersenne61_field_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  input  logic [60:0] in_operand_c,
  input  logic [60:0] in_operand_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [60:0] out_result
);

  m61_pkg::cmd_t  cmd;
  m61_pkg::stat_t stat;

  m61_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  m61_datapath u_dp (
    .clk, .in_op, .in_operand_a, .in_operand_b, .in_operand_c, .in_operand_d,
    .cmd, .stat, .result(out_result)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result != m61_pkg::FieldP) else $error("result not reduced");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready) else $error("load outside idle");
`endif

endmodule

### rtl/m61_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61_datapath: operand registers, add/sub logic and multiply-fold pipeline
// The multiplier runs as four partial products of the 32-bit low and 29-bit high
// operand halves, then a sum stage, then a Mersenne fold.
// ----------------------------------------------------------------------------
module m61_datapath (
  input  logic               clk,
  input  logic [3:0]         in_op,
  input  logic [63:0]        in_operand_a,
  input  logic [63:0]        in_operand_b,
  input  logic [60:0]        in_operand_c,
  input  logic [60:0]        in_operand_d,
  input  m61_pkg::cmd_t      cmd,
  output m61_pkg::stat_t     stat,
  output logic [60:0]        result
);

  logic [3:0]  op_r;
  logic [63:0] ra_r, rb_r;
  logic [60:0] c_r, d_r;
  logic [60:0] acc_r, base_r, res_r;
  logic [60:0] a_f, b_f, c_f, d_f;
  logic [60:0] simple_nxt;
  logic [60:0] mx, my;
  logic [63:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic [121:0] prod_r;
  logic [60:0] prod_red;
  logic [121:0] prod_nxt;
  logic [61:0] mid128, sum3;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      ra_r <= in_operand_a;
      rb_r <= in_operand_b;
      c_r  <= in_operand_c;
      d_r  <= in_operand_d;
    end
  end

  assign a_f = m61_pkg::fold64(ra_r);
  assign b_f = m61_pkg::fold64(rb_r);
  assign c_f = m61_pkg::fold64({3'd0, c_r});
  assign d_f = m61_pkg::fold64({3'd0, d_r});

  assign stat.is_mul = (op_r == m61_pkg::OP_MUL);
  assign stat.is_inv = (op_r == m61_pkg::OP_INV);

  always_comb begin
    mid128 = {1'b0, rb_r[57:0], ra_r[63:61]};
    sum3 = {1'b0, ra_r[60:0]} + mid128[61:0];
    case (op_r)
      m61_pkg::OP_RED64:  simple_nxt = a_f;
      m61_pkg::OP_RED128: simple_nxt = m61_pkg::fold64({2'b0, sum3[61:0]} +
                                                       {58'd0, rb_r[63:58]});
      m61_pkg::OP_NEG:    simple_nxt = (a_f == '0) ? '0 : m61_pkg::FieldP - a_f;
      m61_pkg::OP_ADD2:   simple_nxt = m61_pkg::fadd(a_f, b_f);
      m61_pkg::OP_ADD3:   simple_nxt = m61_pkg::fadd(a_f, m61_pkg::fadd(b_f, c_f));
      m61_pkg::OP_ADD4:   simple_nxt = m61_pkg::fadd(m61_pkg::fadd(a_f, b_f),
                                                     m61_pkg::fadd(c_f, d_f));
      m61_pkg::OP_SUB:    simple_nxt = (a_f >= b_f) ? a_f - b_f
                                                    : m61_pkg::FieldP - b_f + a_f;
      default:            simple_nxt = '0;
    endcase
  end

  always_comb begin
    case (cmd.msel)
      m61_pkg::MSEL_ACC:  begin mx = acc_r;  my = base_r; end
      m61_pkg::MSEL_BASE: begin mx = base_r; my = base_r; end
      default:            begin mx = a_f;    my = b_f;    end
    endcase
  end

  // stage 1: partial products; stage 2: combine; fold is combinational on prod_r
  assign prod_nxt = {58'd0, pp0_r} + {26'd0, pp1_r, 32'd0} + {26'd0, pp2_r, 32'd0}
                  + {pp3_r[57:0], 64'd0};
  always_ff @(posedge clk) begin
    pp0_r  <= {32'd0, mx[31:0]} * {32'd0, my[31:0]};
    pp1_r  <= 64'({32'd0, mx[31:0]} * {32'd0, 3'd0, my[60:32]});
    pp2_r  <= 64'({32'd0, 3'd0, mx[60:32]} * {32'd0, my[31:0]});
    pp3_r  <= 64'({35'd0, mx[60:32]} * {35'd0, my[60:32]});
    prod_r <= prod_nxt;
  end

  always_comb begin
    logic [62:0] s;
    s = {2'b0, prod_r[60:0]} + {2'b0, prod_r[121:61]};
    s = {1'b0, s[61:0]} + {62'd0, s[62]};
    prod_red = m61_pkg::fold64({1'b0, s[62:0]});
  end

  // base starts from the incoming operand, since ra_r is loaded on the same edge
  always_ff @(posedge clk) begin
    if (cmd.load)       acc_r  <= 61'd1;
    else if (cmd.wr_acc) acc_r <= prod_red;
    if (cmd.load)       base_r <= m61_pkg::fold64(in_operand_a);
    else if (cmd.wr_base) base_r <= prod_red;
    if (cmd.simple)          res_r <= simple_nxt;
    else if (cmd.wr_res)     res_r <= prod_red;
    else if (cmd.acc_to_res) res_r <= acc_r;
  end

  assign result = res_r;

endmodule

### rtl/m61_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61_ctrl: request sequencer for the field unit
// Steps simple ops, one multiply, or the square-and-multiply inversion loop.
// ----------------------------------------------------------------------------
module m61_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  m61_pkg::stat_t stat,
  output m61_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_M1   = 7'b0000100,
    S_M2   = 7'b0001000,
    S_M3   = 7'b0010000,
    S_DONE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [m61_pkg::ExpCntW-1:0] bit_r, bit_nxt;
  logic phase_r, phase_nxt; // inversion: 0 = acc multiply, 1 = square
  logic inv_r, inv_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    bit_nxt = bit_r;
    phase_nxt = phase_r;
    inv_nxt = inv_r;
    cmd = '0;
    cmd.msel = m61_pkg::MSEL_AB;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        bit_nxt = '0;
        inv_nxt = stat.is_inv;
        if (stat.is_mul) begin
          state_nxt = S_M1;
        end else if (stat.is_inv) begin
          // skip acc multiply on zero exponent bits
          phase_nxt = ~m61_pkg::InvExp[0];
          state_nxt = S_M1;
        end else begin
          cmd.simple = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_M1: begin
        if (inv_r) cmd.msel = phase_r ? m61_pkg::MSEL_BASE : m61_pkg::MSEL_ACC;
        state_nxt = S_M2;
      end
      S_M2: begin
        if (inv_r) cmd.msel = phase_r ? m61_pkg::MSEL_BASE : m61_pkg::MSEL_ACC;
        state_nxt = S_M3;
      end
      S_M3: begin
        if (!inv_r) begin
          cmd.wr_res = 1'b1;
          state_nxt = S_OUT;
        end else if (!phase_r) begin
          cmd.wr_acc = 1'b1;
          phase_nxt = 1'b1;
          state_nxt = S_M1;
        end else begin
          cmd.wr_base = 1'b1;
          if (bit_r == m61_pkg::ExpLast) begin
            state_nxt = S_DONE;
          end else begin
            bit_nxt = bit_r + 1'b1;
            phase_nxt = ~m61_pkg::InvExp[bit_r + 1'b1];
            state_nxt = S_M1;
          end
        end
      end
      S_DONE: begin
        cmd.acc_to_res = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
      phase_r <= 1'b0;
      inv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      phase_r <= phase_nxt;
      inv_r   <= inv_nxt;
    end
  end

endmodule
